// ===== design/conv_output_tile_shape_defines.svh =====
// Assertion helpers for conv_output_tile_shape.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef CONV_OUTPUT_TILE_SHAPE_DEFINES_SVH
`define CONV_OUTPUT_TILE_SHAPE_DEFINES_SVH

// Same-cycle implication.
`define CTILE_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("conv_output_tile_shape: assertion failed");

// Next-cycle implication.
`define CTILE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("conv_output_tile_shape: assertion failed");

`endif

// ===== design/ctile_pkg.sv =====
`default_nettype none

package ctile_pkg;

  localparam int unsigned NUM_COLS = 4;   // columns in convolution mode, 1..16

  localparam int unsigned DimW  = 12;     // out_height, out_width, tile counts
  localparam int unsigned TileW = 8;      // tile_height, tile_width_per_col
  localparam int unsigned ActW  = 5;      // active column count
  localparam int unsigned DivW  = 12;     // shared divider width

  typedef enum logic [1:0] {
    DSEL_H = 2'd0,   // out_height / tile_height
    DSEL_W = 2'd1,   // out_width / full tile width
    DSEL_S = 2'd2    // partial width / candidate column count
  } div_sel_e;

  typedef struct packed {
    logic     load;         // latch a new item, clear results
    logic     start;        // launch the divider
    div_sel_e sel;          // divider operand select
    logic     cap_h;        // capture height results
    logic     cap_w;        // capture width results
    logic     cap_pw_quot;  // partial width per col = quotient, act = candidate
    logic     cap_pw_part;  // partial width per col = partial width, act = 1
    logic     act_dec;      // try the next lower column count
    logic     out_load;     // move results into the output register
  } ctile_cmd_t;

  typedef struct packed {
    logic err;        // a dimension or tile size is zero
    logic div_busy;
    logic div_done;
    logic rem_zero;   // divider remainder is zero
    logic act_eq2;    // candidate column count is two
  } ctile_sts_t;

endpackage

`default_nettype wire

// ===== design/ctile_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ctile_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ctile_pkg::DivW-1:0] dividend_i,
  input  logic [ctile_pkg::DivW-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [ctile_pkg::DivW-1:0] quot_o,
  output logic [ctile_pkg::DivW-1:0] rem_o
);
  import ctile_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [DivW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [DivW:0]   trial, diff;
  logic            ge;

  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = !diff[DivW];
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = CntW'(DivW);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
      rem_d  = ge ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_d  = {quo_q[DivW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== design/ctile_dp.sv =====
`default_nettype none

module ctile_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ctile_pkg::DimW-1:0]    out_height_i,
  input  logic [ctile_pkg::DimW-1:0]    out_width_i,
  input  logic [ctile_pkg::TileW-1:0]   tile_height_i,
  input  logic [ctile_pkg::TileW-1:0]   tile_width_per_col_i,
  input  logic                          is_conv_i,
  input  ctile_pkg::ctile_cmd_t         cmd_i,
  output ctile_pkg::ctile_sts_t         sts_o,
  output logic [ctile_pkg::DimW-1:0]    tiles_along_height_o,
  output logic [ctile_pkg::DimW-1:0]    full_tiles_along_height_o,
  output logic [ctile_pkg::TileW-1:0]   partial_height_o,
  output logic [ctile_pkg::DimW-1:0]    tiles_along_width_o,
  output logic [ctile_pkg::DimW-1:0]    full_tiles_along_width_o,
  output logic [ctile_pkg::DimW-1:0]    partial_width_per_col_o,
  output logic [ctile_pkg::ActW-1:0]    active_cols_partial_o,
  output logic                          error_o
);
  import ctile_pkg::*;

  // item operands
  logic [DimW-1:0]  oh_q, ow_q, fw_q, part_w_q;
  logic [TileW-1:0] th_q, tw_q;
  logic [ActW-1:0]  act_q;
  logic             err_q;
  // working results
  logic [DimW-1:0]  tiles_h_q, full_h_q, tiles_w_q, full_w_q, pwpc_q;
  logic [TileW-1:0] part_h_q;
  logic [ActW-1:0]  act_res_q;
  // output register
  logic [DimW-1:0]  o_tiles_h_q, o_full_h_q, o_tiles_w_q, o_full_w_q, o_pwpc_q;
  logic [TileW-1:0] o_part_h_q;
  logic [ActW-1:0]  o_act_q;
  logic             o_err_q;

  logic [DivW-1:0]  dvd, dvs, quot, rem;
  logic             div_busy, div_done;
  logic [DimW-1:0]  fw_d, quot_up;
  logic             in_err;

  assign in_err = (out_height_i == '0) || (out_width_i == '0) ||
                  (tile_height_i == '0) || (tile_width_per_col_i == '0);
  assign fw_d   = is_conv_i ? DimW'(DimW'(tile_width_per_col_i) * DimW'(NUM_COLS))
                            : DimW'(tile_width_per_col_i);

  always_comb begin
    case (cmd_i.sel)
      DSEL_H: begin
        dvd = oh_q;
        dvs = DivW'(th_q);
      end
      DSEL_W: begin
        dvd = ow_q;
        dvs = fw_q;
      end
      default: begin
        dvd = part_w_q;
        dvs = DivW'(act_q);
      end
    endcase
  end

  ctile_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // ceiling = floor + 1 when a remainder is left
  assign quot_up = quot + DimW'(rem != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      oh_q      <= out_height_i;
      ow_q      <= out_width_i;
      th_q      <= tile_height_i;
      tw_q      <= tile_width_per_col_i;
      fw_q      <= fw_d;
      act_q     <= is_conv_i ? ActW'(NUM_COLS) : ActW'(1);
      err_q     <= in_err;
      tiles_h_q <= '0;
      full_h_q  <= '0;
      part_h_q  <= '0;
      tiles_w_q <= '0;
      full_w_q  <= '0;
      pwpc_q    <= '0;
      act_res_q <= '0;
    end
    if (cmd_i.cap_h) begin
      tiles_h_q <= quot_up;
      full_h_q  <= quot;
      part_h_q  <= rem[TileW-1:0];   // below tile_height
    end
    if (cmd_i.cap_w) begin
      tiles_w_q <= quot_up;
      full_w_q  <= quot;
      part_w_q  <= rem;
      pwpc_q    <= DimW'(tw_q);      // no partial width unless search overrides
      act_res_q <= '0;
    end
    if (cmd_i.cap_pw_quot) begin
      pwpc_q    <= quot;
      act_res_q <= act_q;
    end
    if (cmd_i.cap_pw_part) begin
      pwpc_q    <= part_w_q;
      act_res_q <= ActW'(1);
    end
    if (cmd_i.act_dec) begin
      act_q <= act_q - 1'b1;
    end
    if (cmd_i.out_load) begin
      o_tiles_h_q <= tiles_h_q;
      o_full_h_q  <= full_h_q;
      o_part_h_q  <= part_h_q;
      o_tiles_w_q <= tiles_w_q;
      o_full_w_q  <= full_w_q;
      o_pwpc_q    <= pwpc_q;
      o_act_q     <= act_res_q;
      o_err_q     <= err_q;
    end
  end

  assign sts_o.err      = err_q;
  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.rem_zero = (rem == '0);
  assign sts_o.act_eq2  = (act_q == ActW'(2));

  assign tiles_along_height_o      = o_tiles_h_q;
  assign full_tiles_along_height_o = o_full_h_q;
  assign partial_height_o          = o_part_h_q;
  assign tiles_along_width_o       = o_tiles_w_q;
  assign full_tiles_along_width_o  = o_full_w_q;
  assign partial_width_per_col_o   = o_pwpc_q;
  assign active_cols_partial_o     = o_act_q;
  assign error_o                   = o_err_q;

endmodule

`default_nettype wire

// ===== design/ctile_ctrl.sv =====
`default_nettype none

module ctile_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ctile_pkg::ctile_cmd_t cmd_o,
  input  ctile_pkg::ctile_sts_t sts_i
);
  import ctile_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CHECK   = 7'b0000010,
    S_DIV_H   = 7'b0000100,
    S_DIV_W   = 7'b0001000,
    S_SRCH_GO = 7'b0010000,
    S_SEARCH  = 7'b0100000,
    S_FINISH  = 7'b1000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.sel  = DSEL_H;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.err) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.sel   = DSEL_H;
          state_d     = S_DIV_H;
        end
      end
      S_DIV_H: begin
        if (sts_i.div_done) begin
          cmd_o.cap_h = 1'b1;
          cmd_o.start = 1'b1;
          cmd_o.sel   = DSEL_W;
          state_d     = S_DIV_W;
        end
      end
      S_DIV_W: begin
        if (sts_i.div_done) begin
          cmd_o.cap_w = 1'b1;
          state_d     = sts_i.rem_zero ? S_FINISH : S_SRCH_GO;
        end
      end
      S_SRCH_GO: begin
        cmd_o.start = 1'b1;
        cmd_o.sel   = DSEL_S;
        state_d     = S_SEARCH;
      end
      S_SEARCH: begin
        cmd_o.sel = DSEL_S;
        if (sts_i.div_done) begin
          if (sts_i.rem_zero) begin
            cmd_o.cap_pw_quot = 1'b1;
            state_d           = S_FINISH;
          end else if (sts_i.act_eq2) begin
            cmd_o.cap_pw_part = 1'b1;
            state_d           = S_FINISH;
          end else begin
            cmd_o.act_dec = 1'b1;
            state_d       = S_SRCH_GO;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/conv_output_tile_shape.sv =====
// Tile shape calculator for one layer's output map. Takes the output height and
// width, the full tile height, the full tile width per column and a convolution
// flag (convolution uses NUM_COLS columns, otherwise one), and returns ceiling
// and floor tile counts along each axis, the partial tile height, and the
// partial width spread over the largest column count (not above the column
// count) that divides it evenly. With no partial width the width per column is
// the full per-column width and the active column count is 0. Any zero
// dimension or tile size gives error = 1 with every other field 0.
// One item is in flight at a time; the next is taken as soon as the current
// one has moved into the output register, even if that result is still
// waiting to be taken. Timing is set by a single shared 12-bit restoring
// divider that yields one quotient bit per cycle. Each item has its fields
// checked, then runs the height and the width division, then, when the width
// leaves a remainder, the partial-width search tries one column count per
// division (up to NUM_COLS - 1 tries in convolution mode, one otherwise), and
// finally its result is loaded into the output register, waiting while the
// previous result has not been taken. The next transfer can be taken in the
// cycle after the result is loaded. An item with a zero field skips the
// divisions and goes from the field check straight to the output register.
`default_nettype none

`include "conv_output_tile_shape_defines.svh"

module conv_output_tile_shape (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ctile_pkg::DimW-1:0]  out_height_i,
  input  logic [ctile_pkg::DimW-1:0]  out_width_i,
  input  logic [ctile_pkg::TileW-1:0] tile_height_i,
  input  logic [ctile_pkg::TileW-1:0] tile_width_per_col_i,
  input  logic                        is_conv_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ctile_pkg::DimW-1:0]  tiles_along_height_o,
  output logic [ctile_pkg::DimW-1:0]  full_tiles_along_height_o,
  output logic [ctile_pkg::TileW-1:0] partial_height_o,
  output logic [ctile_pkg::DimW-1:0]  tiles_along_width_o,
  output logic [ctile_pkg::DimW-1:0]  full_tiles_along_width_o,
  output logic [ctile_pkg::DimW-1:0]  partial_width_per_col_o,
  output logic [ctile_pkg::ActW-1:0]  active_cols_partial_o,
  output logic                        error_o
);
  import ctile_pkg::*;

  ctile_cmd_t cmd;
  ctile_sts_t sts;

  // sequencer: walks height, width and column-search divisions
  ctile_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // operands, shared divider, result and output registers
  ctile_dp u_dp (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .out_height_i              (out_height_i),
    .out_width_i               (out_width_i),
    .tile_height_i             (tile_height_i),
    .tile_width_per_col_i      (tile_width_per_col_i),
    .is_conv_i                 (is_conv_i),
    .cmd_i                     (cmd),
    .sts_o                     (sts),
    .tiles_along_height_o      (tiles_along_height_o),
    .full_tiles_along_height_o (full_tiles_along_height_o),
    .partial_height_o          (partial_height_o),
    .tiles_along_width_o       (tiles_along_width_o),
    .full_tiles_along_width_o  (full_tiles_along_width_o),
    .partial_width_per_col_o   (partial_width_per_col_o),
    .active_cols_partial_o     (active_cols_partial_o),
    .error_o                   (error_o)
  );

  // one item at a time: no second transfer right after the first
  `CTILE_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)

  // the divider is never relaunched mid-division
  `CTILE_ASSERT_IMPL(a_div_idle_on_start, cmd.start, !sts.div_busy)

  // an error result carries only zeros
  `CTILE_ASSERT_IMPL(a_err_zero, out_valid_o && error_o,
    tiles_along_height_o == '0 && full_tiles_along_height_o == '0 &&
    partial_height_o == '0 && tiles_along_width_o == '0 &&
    full_tiles_along_width_o == '0 && partial_width_per_col_o == '0 &&
    active_cols_partial_o == '0)

  // ceiling is floor or floor plus one, and a partial tile never uses
  // more than the column count
  `CTILE_ASSERT_IMPL(a_counts_consistent, out_valid_o && !error_o,
    (tiles_along_height_o == full_tiles_along_height_o ||
     tiles_along_height_o == DimW'(full_tiles_along_height_o + 1'b1)) &&
    (tiles_along_width_o == full_tiles_along_width_o ||
     tiles_along_width_o == DimW'(full_tiles_along_width_o + 1'b1)) &&
    active_cols_partial_o <= ActW'(NUM_COLS))

endmodule

`default_nettype wire

// ===== dv/tb_conv_output_tile_shape.sv =====
`default_nettype none

// Testbench for conv_output_tile_shape.
// Layer jobs go in on the input channel; every accepted job is run through a
// local tile-shape predictor and its expected result is queued. Each result
// transfer on the output channel is checked field by field against the oldest
// queued shape. Both channels idle at random per transfer, and some stretches
// run with no idling at all.

module tb_conv_output_tile_shape;
  timeunit 1ns;
  timeprecision 1ps;

  import ctile_pkg::*;

  // Slowest job plus random idle gaps on each side; the roughly 1300 jobs of
  // the test fit well inside this.
  localparam int unsigned CycleLimit = 600_000;
  // Settling time after the last result, about one worst-case job.
  localparam int unsigned TailCycles = 64;
  localparam int unsigned RandChunks = 10;
  localparam int unsigned ChunkJobs  = 125;

  typedef struct packed {
    logic [DimW-1:0]  out_height;
    logic [DimW-1:0]  out_width;
    logic [TileW-1:0] tile_height;
    logic [TileW-1:0] tile_width_per_col;
    logic             is_conv;
  } layer_job_t;

  typedef struct packed {
    logic [DimW-1:0]  tiles_h;
    logic [DimW-1:0]  full_tiles_h;
    logic [TileW-1:0] part_h;
    logic [DimW-1:0]  tiles_w;
    logic [DimW-1:0]  full_tiles_w;
    logic [DimW-1:0]  part_w_per_col;
    logic [ActW-1:0]  active_cols;
    logic             err;
  } tile_shape_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // All inputs start at known values; from then on they only change by
  // nonblocking assignment on a rising edge.
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [DimW-1:0]  out_height_i = '0;
  logic [DimW-1:0]  out_width_i = '0;
  logic [TileW-1:0] tile_height_i = '0;
  logic [TileW-1:0] tile_width_per_col_i = '0;
  logic             is_conv_i = 1'b0;

  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [DimW-1:0]  tiles_along_height_o;
  logic [DimW-1:0]  full_tiles_along_height_o;
  logic [TileW-1:0] partial_height_o;
  logic [DimW-1:0]  tiles_along_width_o;
  logic [DimW-1:0]  full_tiles_along_width_o;
  logic [DimW-1:0]  partial_width_per_col_o;
  logic [ActW-1:0]  active_cols_partial_o;
  logic             error_o;

  tile_shape_t shape_expect_q[$];
  tile_shape_t shape_want;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Random idle enables for the two sides; cleared for back-to-back stretches.
  logic src_idle_en = 1'b1;
  logic snk_idle_en = 1'b1;

  conv_output_tile_shape DUT (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .in_valid_i                (in_valid_i),
    .in_ready_o                (in_ready_o),
    .out_height_i              (out_height_i),
    .out_width_i               (out_width_i),
    .tile_height_i             (tile_height_i),
    .tile_width_per_col_i      (tile_width_per_col_i),
    .is_conv_i                 (is_conv_i),
    .out_valid_o               (out_valid_o),
    .out_ready_i               (out_ready_i),
    .tiles_along_height_o      (tiles_along_height_o),
    .full_tiles_along_height_o (full_tiles_along_height_o),
    .partial_height_o          (partial_height_o),
    .tiles_along_width_o       (tiles_along_width_o),
    .full_tiles_along_width_o  (full_tiles_along_width_o),
    .partial_width_per_col_o   (partial_width_per_col_o),
    .active_cols_partial_o     (active_cols_partial_o),
    .error_o                   (error_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tile-shape predictor
  // ---------------------------------------------------------------------------

  // Ceiling/floor tile counts per axis. The partial width (remainder of the
  // width over the full tile width) goes to the largest column count, not above
  // the mode's column count, that divides it evenly.
  function automatic tile_shape_t predict_shape(layer_job_t job);
    tile_shape_t r;
    int unsigned oh, ow, th, tw, cols, full_w, rem_w, act;
    r  = '0;
    oh = 32'(job.out_height);
    ow = 32'(job.out_width);
    th = 32'(job.tile_height);
    tw = 32'(job.tile_width_per_col);
    // Zero dimension or tile size: flag only, every count stays zero.
    if (oh == 0 || ow == 0 || th == 0 || tw == 0) begin
      r.err = 1'b1;
      return r;
    end
    cols   = job.is_conv ? NUM_COLS : 1;
    full_w = tw * cols;
    rem_w  = ow % full_w;
    r.tiles_h      = DimW'((oh - 1) / th + 1);
    r.full_tiles_h = DimW'(oh / th);
    r.part_h       = TileW'(oh % th);
    r.tiles_w      = DimW'((ow - 1) / full_w + 1);
    r.full_tiles_w = DimW'(ow / full_w);
    if (rem_w == 0) begin
      // No partial width: report the full per-column width, no active columns.
      r.part_w_per_col = DimW'(tw);
      r.active_cols    = '0;
    end else begin
      act = cols;
      while (act > 1 && (rem_w % act) != 0) act--;
      r.part_w_per_col = DimW'(rem_w / act);
      r.active_cols    = ActW'(act);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Input monitor: predict at the transfer, so the queue holds exactly what
  // the block took in.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      shape_expect_q.push_back(predict_shape('{out_height_i, out_width_i, tile_height_i,
                                               tile_width_per_col_i, is_conv_i}));
  end

  // Result checker: one result per job, in order.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (shape_expect_q.size() == 0) begin
        report_error("result transfer with no job pending");
      end else begin
        shape_want = shape_expect_q.pop_front();
        check_field("tiles_along_height", 32'(tiles_along_height_o),
                    32'(shape_want.tiles_h));
        check_field("full_tiles_along_height", 32'(full_tiles_along_height_o),
                    32'(shape_want.full_tiles_h));
        check_field("partial_height", 32'(partial_height_o), 32'(shape_want.part_h));
        check_field("tiles_along_width", 32'(tiles_along_width_o),
                    32'(shape_want.tiles_w));
        check_field("full_tiles_along_width", 32'(full_tiles_along_width_o),
                    32'(shape_want.full_tiles_w));
        check_field("partial_width_per_col", 32'(partial_width_per_col_o),
                    32'(shape_want.part_w_per_col));
        check_field("active_cols_partial", 32'(active_cols_partial_o),
                    32'(shape_want.active_cols));
        check_field("error", 32'(error_o), 32'(shape_want.err));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: per transfer, hold ready low for a random stall, then keep it
  // high until the next result is taken. With idling off ready stays high.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = snk_idle_en ? $urandom_range(0, 9) : 0;
      repeat (stall) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Job side
  // ---------------------------------------------------------------------------

  // Entered and left on a rising edge. Valid is left high after the transfer
  // so a following job with no gap reuses it; anything that lets time pass
  // afterwards must lower it in the same step (see wait_for_results).
  task automatic send_job(layer_job_t job);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    out_height_i         <= job.out_height;
    out_width_i          <= job.out_width;
    tile_height_i        <= job.tile_height;
    tile_width_per_col_i <= job.tile_width_per_col;
    is_conv_i            <= job.is_conv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Hold off new jobs until every pending result has been taken. It lets the
  // current edge pass first, so the monitor has queued the job taken at it.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (shape_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly small or full-range values; zero and the maximum now and then.
  function automatic int unsigned pick_value(int unsigned max_val, int unsigned low_max);
    int unsigned sel;
    sel = $urandom_range(0, 63);
    if (sel == 0) return 0;
    if (sel <= 2) return max_val;
    if (sel <= 24) return $urandom_range(1, low_max);
    return $urandom_range(1, max_val);
  endfunction

  // Each zero field alone, then all zero: error flag with zero counts.
  task automatic test_zero_dims();
    send_job('{12'd0,   12'd100, 8'd8,  8'd4,  1'b1});
    send_job('{12'd100, 12'd0,   8'd8,  8'd4,  1'b1});
    send_job('{12'd100, 12'd100, 8'd0,  8'd4,  1'b0});
    send_job('{12'd100, 12'd100, 8'd8,  8'd0,  1'b1});
    send_job('{12'd0,   12'd0,   8'd0,  8'd0,  1'b0});
  endtask

  task automatic test_extremes();
    send_job('{12'd4095, 12'd4095, 8'd255, 8'd255, 1'b1});
    send_job('{12'd4095, 12'd4095, 8'd255, 8'd255, 1'b0});
    send_job('{12'd4095, 12'd4095, 8'd1,   8'd1,   1'b0});  // 4095 tiles per axis
    send_job('{12'd4095, 12'd4095, 8'd1,   8'd1,   1'b1});
    send_job('{12'd1,    12'd1,    8'd255, 8'd255, 1'b1});  // map smaller than one tile
    send_job('{12'd254,  12'd255,  8'd255, 8'd255, 1'b0});  // largest partial height
    send_job('{12'd255,  12'd2040, 8'd255, 8'd255, 1'b1});  // exact multiples
  endtask

  // Full tile width 40 in conv mode: partial widths that land on each
  // active column count, none, and a map narrower than one tile.
  task automatic test_width_split();
    send_job('{12'd17, 12'd52, 8'd5, 8'd10, 1'b1});  // 12 over 4 columns
    send_job('{12'd17, 12'd49, 8'd5, 8'd10, 1'b1});  // 9 over 3
    send_job('{12'd17, 12'd42, 8'd5, 8'd10, 1'b1});  // 2 over 2
    send_job('{12'd17, 12'd47, 8'd5, 8'd10, 1'b1});  // 7 over 1
    send_job('{12'd17, 12'd80, 8'd5, 8'd10, 1'b1});  // no partial width
    send_job('{12'd17, 12'd5,  8'd5, 8'd10, 1'b1});  // narrower than one tile
    send_job('{12'd17, 12'd27, 8'd5, 8'd10, 1'b0});  // single column, partial 7
    send_job('{12'd17, 12'd30, 8'd5, 8'd10, 1'b0});  // single column, none
  endtask

  // Random jobs in chunks; the chunk number decides which sides idle so
  // both back-to-back and gappy traffic hit every phase of a division.
  task automatic test_random_layers();
    layer_job_t job;
    for (int unsigned c = 0; c < RandChunks; c++) begin
      src_idle_en = (c % 3 != 2);
      snk_idle_en = (c % 4 != 3);
      for (int unsigned n = 0; n < ChunkJobs; n++) begin
        job.out_height         = DimW'(pick_value(4095, 64));
        job.out_width          = DimW'(pick_value(4095, 256));
        job.tile_height        = TileW'(pick_value(255, 16));
        job.tile_width_per_col = TileW'(pick_value(255, 16));
        job.is_conv            = 1'($urandom_range(0, 1));
        send_job(job);
      end
      // Drain every few chunks so the block also starts from an empty pipe.
      if (c % 4 == 1) wait_for_results();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_dims();
    wait_for_results();
    test_extremes();
    wait_for_results();
    test_width_split();
    wait_for_results();
    test_random_layers();
    wait_for_results();

    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/ctile_pkg.sv
design/ctile_div.sv
design/ctile_dp.sv
design/ctile_ctrl.sv
design/conv_output_tile_shape.sv
dv/tb_conv_output_tile_shape.sv
